// ===== rtl/tri3d_pkg.sv =====
// Package with the transaction types and fixed widths of the triangle area block.
`timescale 1ns / 1ps
`default_nettype none
package tri3d_pkg;

  localparam int COORD_W = 32;
  localparam int AREA_W  = 64;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex0_x;
    logic signed [COORD_W-1:0] vertex0_y;
    logic signed [COORD_W-1:0] vertex0_z;
    logic signed [COORD_W-1:0] vertex1_x;
    logic signed [COORD_W-1:0] vertex1_y;
    logic signed [COORD_W-1:0] vertex1_z;
    logic signed [COORD_W-1:0] vertex2_x;
    logic signed [COORD_W-1:0] vertex2_y;
    logic signed [COORD_W-1:0] vertex2_z;
  } in_item_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    logic              degenerate;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/tri3d_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module tri3d_sqrt #(
  parameter int OP_W  = 100,
  parameter int TAG_W = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [TAG_W-1:0]    in_tag,
  output logic                     out_valid,
  output logic [(OP_W+1)/2-1:0]    out_root,
  output logic [TAG_W-1:0]         out_tag
);
  localparam int RW = (OP_W + 1) / 2;
  localparam int PW = 2 * RW;

  // Restoring style: remainder and root advance one bit per stage.
  logic [PW-1:0]    op_r   [1:RW];
  logic [RW+1:0]    rem_r  [1:RW];
  logic [RW-1:0]    root_r [1:RW];
  logic [TAG_W-1:0] tag_r  [1:RW];
  logic             vld_r  [1:RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [PW-1:0]    op_c;
    logic [RW+1:0]    rem_c;
    logic [RW-1:0]    root_c;
    logic [TAG_W-1:0] tag_c;
    logic             vld_c;
    logic [RW+1:0]    trial;
    logic [RW+1:0]    sub;
    logic [RW+1:0]    rem_nxt;
    logic [RW-1:0]    root_nxt;
    if (s == 0) begin : g_first
      always_comb begin
        op_c   = PW'(in_op);
        rem_c  = '0;
        root_c = '0;
        tag_c  = in_tag;
        vld_c  = in_valid;
      end
    end else begin : g_next
      always_comb begin
        op_c   = op_r[s];
        rem_c  = rem_r[s];
        root_c = root_r[s];
        tag_c  = tag_r[s];
        vld_c  = vld_r[s];
      end
    end
    always_comb begin
      trial = {rem_c[RW-1:0], op_c[PW-1 -: 2]};
      sub   = {root_c, 2'b01};
      if (trial >= sub) begin
        rem_nxt  = trial - sub;
        root_nxt = {root_c[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = trial;
        root_nxt = {root_c[RW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_c;
      end
      op_r[s+1]   <= {op_c[PW-3:0], 2'b00};
      rem_r[s+1]  <= rem_nxt;
      root_r[s+1] <= root_nxt;
      tag_r[s+1]  <= tag_c;
    end
  end

  assign out_valid = vld_r[RW];
  assign out_root  = root_r[RW];
  assign out_tag   = tag_r[RW];
endmodule
`default_nettype wire

// ===== rtl/triangle_area_3d.sv =====
// Top level of the pipelined 3D triangle area unit.
`timescale 1ns / 1ps
`default_nettype none
// Computes the area of a 3D triangle by Heron's formula, in signed fixed point
// coordinates. A transaction is accepted whenever start is high; busy is always
// low, since the pipeline takes a new triangle in every cycle and the receiver
// cannot stall it. Each result appears on the out_ ports for one cycle with
// out_valid high. A result passes through registers for the differences, squares
// and sums, a chain of edge square root stages (one per root bit), Heron stages A
// to D for the product, then one stage per bit of the area square root and an
// output register. The two square root pipelines set the latency; throughput is
// one triangle per clock.
module triangle_area_3d #(
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tri3d_pkg::in_item_t in_item,
  output logic                     out_valid,
  output tri3d_pkg::out_item_t     out_item
);
  localparam int CW  = tri3d_pkg::COORD_W;
  localparam int DW  = CW;            // absolute difference width
  localparam int SQW = 2 * DW + 2;    // sum of three squares
  localparam int EW  = (SQW + 1) / 2; // edge length width
  localparam int AW  = EW + 2;        // a+b+c width
  localparam int PW  = 4 * AW;        // full product width
  localparam int SH  = 4 + 2 * FRAC_BITS;
  localparam int QW  = PW - SH;       // truncated product width
  localparam int RW  = (QW + 1) / 2;
  localparam int OW  = tri3d_pkg::AREA_W;

  assign busy = 1'b0;

  logic [CW-1:0] crd [9];
  always_comb begin
    crd[0] = CW'(in_item.vertex0_x); crd[1] = CW'(in_item.vertex0_y);
    crd[2] = CW'(in_item.vertex0_z); crd[3] = CW'(in_item.vertex1_x);
    crd[4] = CW'(in_item.vertex1_y); crd[5] = CW'(in_item.vertex1_z);
    crd[6] = CW'(in_item.vertex2_x); crd[7] = CW'(in_item.vertex2_y);
    crd[8] = CW'(in_item.vertex2_z);
  end

  // Stage 1: absolute differences per edge (0-1, 0-2, 1-2) and axis.
  logic [DW-1:0] dif_r [9];
  logic          s1_vld_r;
  for (genvar e = 0; e < 3; e++) begin : g_dif
    localparam int P = (e == 2) ? 1 : 0;
    localparam int Q = (e == 0) ? 1 : 2;
    for (genvar k = 0; k < 3; k++) begin : g_ax
      logic signed [CW:0] u, v, d;
      always_comb begin
        u = {crd[P*3+k][CW-1], crd[P*3+k]};
        v = {crd[Q*3+k][CW-1], crd[Q*3+k]};
        d = u - v;
      end
      always_ff @(posedge clk) begin
        dif_r[e*3+k] <= d[CW] ? DW'(-d) : DW'(d);
      end
    end
  end

  // Stage 2: squares.  Stage 3: sums of squares.
  logic [2*DW-1:0] sq_r [9];
  logic [SQW-1:0]  ssq_r [3];
  logic            s2_vld_r, s3_vld_r;
  for (genvar i = 0; i < 9; i++) begin : g_sq
    always_ff @(posedge clk) sq_r[i] <= dif_r[i] * dif_r[i];
  end
  for (genvar e = 0; e < 3; e++) begin : g_ssq
    always_ff @(posedge clk) begin
      ssq_r[e] <= SQW'(sq_r[e*3]) + SQW'(sq_r[e*3+1]) + SQW'(sq_r[e*3+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0; s2_vld_r <= 1'b0; s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start; s2_vld_r <= s1_vld_r; s3_vld_r <= s2_vld_r;
    end
  end

  // Edge lengths: three root pipelines in lock step.
  logic [EW-1:0] edg [3];
  logic          ev [3];
  for (genvar e = 0; e < 3; e++) begin : g_esq
    logic unused_tag;
    tri3d_sqrt #(.OP_W(SQW), .TAG_W(1)) u_esqrt (
      .clk(clk), .rst_n(rst_n), .in_valid(s3_vld_r), .in_op(ssq_r[e]),
      .in_tag(1'b0), .out_valid(ev[e]), .out_root(edg[e]), .out_tag(unused_tag)
    );
  end

  // Heron stage A: the four factors and triangle check.
  logic [AW-1:0] fa_r, fb_r, fc_r, fd_r;
  logic          ha_vld_r, ha_bad_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ha_vld_r <= 1'b0;
    else ha_vld_r <= ev[0];
    fa_r <= AW'(edg[0]) + AW'(edg[1]) + AW'(edg[2]);
    fb_r <= AW'(edg[1]) + AW'(edg[2]) - AW'(edg[0]);
    fc_r <= AW'(edg[0]) + AW'(edg[2]) - AW'(edg[1]);
    fd_r <= AW'(edg[0]) + AW'(edg[1]) - AW'(edg[2]);
    ha_bad_r <= (AW'(edg[1]) + AW'(edg[2]) <= AW'(edg[0])) ||
                (AW'(edg[0]) + AW'(edg[2]) <= AW'(edg[1])) ||
                (AW'(edg[0]) + AW'(edg[1]) <= AW'(edg[2]));
  end

  // Heron stage B: two pair products. Stage C: the four half-width partial
  // products of their product. Stage D: the partial products summed at their
  // weights and truncated.
  logic [2*AW-1:0] pab_r, pcd_r;
  logic [2*AW-1:0] pll_r, plh_r, phl_r, phh_r;
  logic [QW-1:0]   prod_r;
  logic            hb_vld_r, hb_bad_r, hp_vld_r, hp_bad_r, hc_vld_r, hc_bad_r;
  logic [PW-1:0]   prod_full;
  assign prod_full = PW'(pll_r) + (PW'(plh_r) << AW) + (PW'(phl_r) << AW) +
                     (PW'(phh_r) << (2 * AW));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_vld_r <= 1'b0; hp_vld_r <= 1'b0; hc_vld_r <= 1'b0;
    end else begin
      hb_vld_r <= ha_vld_r; hp_vld_r <= hb_vld_r; hc_vld_r <= hp_vld_r;
    end
    pab_r    <= fa_r * fb_r;
    pcd_r    <= fc_r * fd_r;
    hb_bad_r <= ha_bad_r;
    pll_r    <= pab_r[AW-1:0] * pcd_r[AW-1:0];
    plh_r    <= pab_r[AW-1:0] * pcd_r[2*AW-1:AW];
    phl_r    <= pab_r[2*AW-1:AW] * pcd_r[AW-1:0];
    phh_r    <= pab_r[2*AW-1:AW] * pcd_r[2*AW-1:AW];
    hp_bad_r <= hb_bad_r;
    prod_r   <= prod_full[PW-1:SH];
    hc_bad_r <= hp_bad_r;
  end

  logic          deg_in;
  assign deg_in = hc_bad_r || (prod_r == '0);

  logic          rv;
  logic [RW-1:0] root;
  logic          rdeg;
  tri3d_sqrt #(.OP_W(QW), .TAG_W(1)) u_asqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(hc_vld_r), .in_op(prod_r),
    .in_tag(deg_in), .out_valid(rv), .out_root(root), .out_tag(rdeg)
  );

  // Output register with saturation and degenerate forcing.
  logic ovf;
  if (RW > OW) begin : g_ovf
    assign ovf = |root[RW-1:(RW > OW ? OW : 0)];
  end else begin : g_novf
    assign ovf = 1'b0;
  end

  logic                 out_valid_r;
  tri3d_pkg::out_item_t out_item_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= rv;
    if (rdeg) begin
      out_item_r.area <= '0; out_item_r.degenerate <= 1'b1;
    end else if (ovf) begin
      out_item_r.area <= '1; out_item_r.degenerate <= 1'b0;
    end else begin
      out_item_r.area <= OW'(root); out_item_r.degenerate <= 1'b0;
    end
  end
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A degenerate result always reports zero area.
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.degenerate |-> out_item.area == '0)
    else $error("degenerate result with nonzero area");
  // Accepted transactions reach the first stage.
  a_s1: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> s1_vld_r) else $error("transaction lost at entry");
  // The busy output never asserts.
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule
`default_nettype wire

// ===== verif/triangle_area_3d_test.sv =====
// Self-checking testbench for the 3D triangle area unit, with a Heron's formula predictor.
`timescale 1ns / 1ps
`default_nettype none

// Keeps the areas still owed by the block and compares each result, in arrival order,
// against the oldest one.
class area_scoreboard;
  tri3d_pkg::out_item_t pending_areas[$];
  int unsigned          mismatches;
  int unsigned          triangles_seen;
  int unsigned          flat_seen;

  function new();
    mismatches     = 0;
    triangles_seen = 0;
    flat_seen      = 0;
  endfunction

  // Floor square root of an operand below 2^256.
  static function logic [127:0] floor_root(logic [255:0] n);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if ((256'(t) * 256'(t)) <= n) r = t;
    end
    return r;
  endfunction

  // Edge length in Q.16: root of the exact sum of squared coordinate differences.
  static function logic [63:0] edge_len(logic [31:0] p[3], logic [31:0] q[3]);
    logic [255:0] sum;
    logic [32:0]  u;
    logic [32:0]  v;
    logic [32:0]  d;
    logic [127:0] r;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      // Offset binary keeps the ordering when compared as unsigned.
      u   = {1'b0, ~p[k][31], p[k][30:0]};
      v   = {1'b0, ~q[k][31], q[k][30:0]};
      d   = (u > v) ? u - v : v - u;
      sum = sum + 256'(d) * 256'(d);
    end
    r = floor_root(sum);
    return r[63:0];
  endfunction

  function void note_triangle(tri3d_pkg::in_item_t t);
    logic [31:0]          v0[3];
    logic [31:0]          v1[3];
    logic [31:0]          v2[3];
    logic [63:0]          a;
    logic [63:0]          b;
    logic [63:0]          c;
    logic [255:0]         prod;
    logic [127:0]         root;
    tri3d_pkg::out_item_t want;
    v0 = '{t.vertex0_x, t.vertex0_y, t.vertex0_z};
    v1 = '{t.vertex1_x, t.vertex1_y, t.vertex1_z};
    v2 = '{t.vertex2_x, t.vertex2_y, t.vertex2_z};
    a  = edge_len(v0, v1);
    b  = edge_len(v0, v2);
    c  = edge_len(v1, v2);
    want.area       = '0;
    want.degenerate = 1'b1;
    triangles_seen++;
    if (!(b + c <= a || a + c <= b || a + b <= c)) begin
      prod = 256'(a + b + c) * 256'(b + c - a) * 256'(a + c - b) * 256'(a + b - c);
      // Divide by 16 and drop 32 of the 64 fraction bits of the four-factor product.
      prod = prod >> 36;
      if (prod != '0) begin
        root = floor_root(prod);
        if (root[127:64] != '0) begin
          want.area = '1;
        end else begin
          want.area = root[63:0];
        end
        want.degenerate = 1'b0;
      end
    end
    if (want.degenerate) flat_seen++;
    pending_areas.push_back(want);
  endfunction

  function void check_area(tri3d_pkg::out_item_t got);
    tri3d_pkg::out_item_t want;
    if (pending_areas.size() == 0) begin
      $error("area result with no triangle outstanding: area=%h degenerate=%b",
             got.area, got.degenerate);
      mismatches++;
      return;
    end
    want = pending_areas.pop_front();
    if (got.area !== want.area) begin
      $error("area: expected %h, actual %h", want.area, got.area);
      mismatches++;
    end
    if (got.degenerate !== want.degenerate) begin
      $error("degenerate: expected %b, actual %b", want.degenerate, got.degenerate);
      mismatches++;
    end
  endfunction
endclass

module triangle_area_3d_test;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  tri3d_pkg::in_item_t  in_item;
  logic                 out_valid;
  tri3d_pkg::out_item_t out_item;

  area_scoreboard scoreboard;
  int unsigned    num_random;
  bit             quiet_tail;

  triangle_area_3d DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Results are sampled in the middle of their cycle, well clear of the edge.
  always @(negedge clk) begin
    if (rst_n && out_valid) scoreboard.check_area(out_item);
  end

  // Offers one triangle and holds it until the block takes it. Busy is looked at
  // mid-cycle, so the decision does not race the edge that updates it.
  task automatic send_triangle(tri3d_pkg::in_item_t t);
    bit taken;
    start   <= 1'b1;
    in_item <= t;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    scoreboard.note_triangle(t);
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic tri3d_pkg::in_item_t pack_vertices(logic [31:0] p[9]);
    return {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]};
  endfunction

  // A coordinate near the origin, a few units either way, in Q16.16.
  function automatic logic [31:0] near_coord();
    return 32'($signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000);
  endfunction

  // A random triangle. Half are small and near the origin; the rest use the whole
  // range, repeat a vertex, put all three vertices on one line, or form a sliver.
  function automatic tri3d_pkg::in_item_t random_triangle();
    logic [31:0] p[9];
    int unsigned kind;
    int          k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) p[i] = (kind < 5) ? near_coord() : $urandom();
    if (kind == 7) begin
      // Two vertices coincide.
      for (int i = 0; i < 3; i++) p[6 + i] = p[$urandom_range(0, 1) * 3 + i];
    end else if (kind == 8) begin
      // Collinear: third vertex is the first plus a small multiple of the edge.
      k = $urandom_range(0, 4) - 2;
      for (int i = 0; i < 3; i++) begin
        p[i]     = near_coord();
        p[3 + i] = near_coord();
        p[6 + i] = p[i] + k * (p[3 + i] - p[i]);
      end
    end else if (kind == 9) begin
      // Sliver: nearly collinear, so rounding of the edges decides the outcome.
      for (int i = 0; i < 3; i++) begin
        p[6 + i] = p[i] + 2 * (p[3 + i] - p[i]) + 32'($urandom_range(0, 2)) - 32'd1;
      end
    end
    return pack_vertices(p);
  endfunction

  initial begin
    logic [31:0] p[9];
    int unsigned wait_cycles;

    scoreboard = new();
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    quiet_tail = 1'b0;
    num_random = 850;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. All vertices at the origin: every edge is zero.
    send_triangle('0);
    // Unit right triangle in the xy plane.
    p = '{0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0};
    send_triangle(pack_vertices(p));
    // An equilateral triangle with negative unit coordinates on the three axes.
    p = '{32'hFFFF_0000, 0, 0, 0, 0, 32'hFFFF_0000, 0, 32'hFFFF_0000, 0};
    send_triangle(pack_vertices(p));
    // Three collinear points.
    p = '{0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
          32'h0002_0000, 32'h0002_0000, 32'h0002_0000};
    send_triangle(pack_vertices(p));
    // Smallest step in each direction: the product truncates away.
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_triangle(pack_vertices(p));
    // Corners of the coordinate range: the largest edges and area.
    p = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send_triangle(pack_vertices(p));
    p = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    send_triangle(pack_vertices(p));
    // Every coordinate at the most negative value, then all at the most positive.
    for (int i = 0; i < 9; i++) p[i] = 32'h8000_0000;
    send_triangle(pack_vertices(p));
    for (int i = 0; i < 9; i++) p[i] = 32'h7FFF_FFFF;
    send_triangle(pack_vertices(p));
    // Near-equilateral triangle and a long thin sliver.
    p = '{0, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 32'h0001_BB68, 0};
    send_triangle(pack_vertices(p));
    p = '{0, 0, 0, 32'h4000_0000, 0, 0, 32'h2000_0000, 1, 0};
    send_triangle(pack_vertices(p));
    // Alternating bit patterns.
    for (int i = 0; i < 9; i++) p[i] = (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555;
    send_triangle(pack_vertices(p));
    for (int i = 0; i < 9; i++) p[i] = (i % 3 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555;
    send_triangle(pack_vertices(p));

    // Random part. Bursts of idle cycles on the input, none in the final stretch.
    for (int n = 0; n < num_random; n++) begin
      if (n >= num_random - 120) quiet_tail = 1'b1;
      if (!quiet_tail && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 13));
      send_triangle(random_triangle());
    end
    start <= 1'b0;

    // Drain: wait for every outstanding area, then give the pipeline time to
    // show any result nobody asked for.
    wait_cycles = 0;
    while (scoreboard.pending_areas.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (400) @(posedge clk);

    $display("Checked %0d triangles, %0d of them degenerate, with random idle on input.",
             scoreboard.triangles_seen, scoreboard.flat_seen);
    if (scoreboard.mismatches == 0 && scoreboard.pending_areas.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("Timed out waiting for the block.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
